[rtl/rfcrc_pkg.sv]
package rfcrc_pkg;

  localparam logic [15:0] CrcPolyReset = 16'h8005;
  localparam int unsigned MinFrameBytes = 3;

  // Eight-bit CRC update: data fed LSB first, register shifted MSB first
  function automatic logic [15:0] crc_feed_byte(input logic [15:0] crc_in,
                                                input logic [7:0]  data,
                                                input logic [15:0] poly);
    logic [15:0] crc;
    logic        fb;
    crc = crc_in;
    for (int i = 0; i < 8; i++) begin
      fb  = data[i] ^ crc[15];
      crc = {crc[14:0], 1'b0};
      if (fb) begin
        crc = crc ^ poly;
      end
    end
    return crc;
  endfunction

endpackage

[rtl/rfcrc_if.sv]
// Byte input channel
interface rfcrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

// Frame result channel
interface rfcrc_out_if;
  logic        valid;
  logic        ready;
  logic        crc_ok;
  logic [15:0] crc_value;
  logic [7:0]  status_byte;
  logic        length_error;

  modport source (output valid, output crc_ok, output crc_value, output status_byte,
                  output length_error, input ready);
  modport sink   (input valid, input crc_ok, input crc_value, input status_byte,
                  input length_error, output ready);
endinterface

// Polynomial write channel
interface rfcrc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] crc_polynomial;

  modport source (output valid, output crc_polynomial, input ready);
  modport sink   (input valid, input crc_polynomial, output ready);
endinterface

[rtl/response_frame_crc16_checker_top.sv]
// Response-frame CRC-16 checker.
// Frame bytes arrive on in_i, one per transfer; frame_start marks the count
// byte, which restarts any frame in progress. The CRC (initial zero) runs
// over the first count-2 bytes; the last two bytes carry the expected CRC,
// low byte first. One result leaves on out_o per frame: at the last byte, or
// at once for a count below 3 or above MAX_FRAME_BYTES (length_error set).
// cfg_i writes the generator polynomial; write only while no frame is open.
// Throughput: one byte per cycle while out_o is not stalled. The eight-bit
// CRC update is unrolled between the input register and the crc_q register.
// A frame's result is registered: the closing byte passes the input register,
// then the result register, before the result is valid on out_o.
// Reset: no frame open, both registers empty, polynomial back to 0x8005.
// Stall: a result waiting on out_o holds the input register; with the input
// register full too, in_i.ready drops until the receiver takes the result.
module response_frame_crc16_checker_top #(
  parameter int unsigned MAX_FRAME_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rfcrc_in_if.sink    in_i,
  rfcrc_cfg_if.sink   cfg_i,
  rfcrc_out_if.source out_o
);
  import rfcrc_pkg::*;

  localparam logic [7:0] MaxBytes = 8'(MAX_FRAME_BYTES);
  localparam logic [7:0] MinBytes = 8'(MinFrameBytes);

  // Configuration register
  logic [15:0] poly_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= CrcPolyReset;
    end else if (cfg_i.valid) begin
      poly_q <= cfg_i.crc_polynomial;
    end
  end

  // Input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_start_q;
  logic       s1_adv;
  logic       in_take;

  assign s1_adv     = s1_valid_q && (!out_o.valid || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q  <= in_i.data_byte;
      s1_start_q <= in_i.frame_start;
    end
  end

  // Frame state
  logic        active_q, active_d;
  logic [6:0]  pos_q, pos_d;
  logic [6:0]  total_q, total_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  status_q, status_d;
  logic [7:0]  crc_lo_q, crc_lo_d;

  // Result of the byte in the input register
  logic        res_hit;
  logic        res_ok;
  logic [15:0] res_crc;
  logic [7:0]  res_status;
  logic        res_len_err;

  logic        len_bad;
  logic [7:0]  pos_plus2;
  logic [7:0]  total_ext;

  assign len_bad   = (s1_byte_q < MinBytes) || (s1_byte_q > MaxBytes);
  assign pos_plus2 = {1'b0, pos_q} + 8'd2;
  assign total_ext = {1'b0, total_q};

  always_comb begin
    active_d    = active_q;
    pos_d       = pos_q;
    total_d     = total_q;
    crc_d       = crc_q;
    status_d    = status_q;
    crc_lo_d    = crc_lo_q;
    res_hit     = 1'b0;
    res_ok      = 1'b0;
    res_crc     = 16'h0000;
    res_status  = 8'h00;
    res_len_err = 1'b0;
    if (s1_start_q) begin
      if (len_bad) begin
        // bad count: report at once, stay idle
        active_d    = 1'b0;
        crc_d       = 16'h0000;
        pos_d       = 7'd0;
        res_hit     = 1'b1;
        res_len_err = 1'b1;
      end else begin
        active_d = 1'b1;
        total_d  = s1_byte_q[6:0];
        crc_d    = crc_feed_byte(16'h0000, s1_byte_q, poly_q);
        pos_d    = 7'd1;
      end
    end else if (active_q) begin
      if (pos_q == 7'd1) begin
        status_d = s1_byte_q;
      end
      if (pos_plus2 < total_ext) begin
        crc_d = crc_feed_byte(crc_q, s1_byte_q, poly_q);
        pos_d = pos_q + 7'd1;
      end else if (pos_plus2 == total_ext) begin
        crc_lo_d = s1_byte_q;
        pos_d    = pos_q + 7'd1;
      end else begin
        // last byte: compare against the received CRC
        res_hit    = 1'b1;
        res_ok     = (s1_byte_q == crc_q[15:8]) && (crc_lo_q == crc_q[7:0]);
        res_crc    = crc_q;
        res_status = status_d;
        active_d   = 1'b0;
        pos_d      = 7'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pos_q    <= 7'd0;
      total_q  <= 7'd0;
    end else if (s1_adv) begin
      active_q <= active_d;
      pos_q    <= pos_d;
      total_q  <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      crc_q    <= crc_d;
      status_q <= status_d;
      crc_lo_q <= crc_lo_d;
    end
  end

  // Result register
  logic        out_valid_q;
  logic        out_ok_q;
  logic [15:0] out_crc_q;
  logic [7:0]  out_status_q;
  logic        out_len_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= res_hit;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && res_hit) begin
      out_ok_q      <= res_ok;
      out_crc_q     <= res_crc;
      out_status_q  <= res_status;
      out_len_err_q <= res_len_err;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.crc_ok       = out_ok_q;
  assign out_o.crc_value    = out_crc_q;
  assign out_o.status_byte  = out_status_q;
  assign out_o.length_error = out_len_err_q;

  // Checks
  a_len_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_len_err_q) |-> (!out_ok_q && out_crc_q == 16'h0000))
    else $error("length error result carries non-zero fields");

  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> ({1'b0, total_q} >= MinBytes && {1'b0, total_q} <= MaxBytes))
    else $error("open frame with out-of-range count");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (pos_q != 7'd0 && pos_q < total_q))
    else $error("byte position outside open frame");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_byte_q) && $stable(s1_start_q)))
    else $error("input register changed while stalled");

  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !s1_start_q && !active_q) |=> !out_valid_q)
    else $error("result from a byte outside any frame");

endmodule
